// File: rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer package
// Shared constants and the result record passed between the deframer stages.
// ----------------------------------------------------------------------------
package lpd_pkg;

   // Parser phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_BODY    = 2'd1;
   localparam logic [1:0] PH_DISCARD = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Header layout: command id at bytes 2-3, body length at bytes 4-7
   localparam int HDR_CMD_OFFSET = 2;
   localparam int HDR_LEN_OFFSET = 4;
   localparam int LEN_BYTES      = 4;

   localparam logic [31:0] MAX_BODY_RESET = 32'd8192;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  body_byte;
      logic [15:0] command_code;
      logic [31:0] frame_body_length;
      logic        packet_last;
   } result_type;

endpackage

// File: rtl/lpd_frame_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Tracks header, body and discard phases and forms at most one result per request.
// ----------------------------------------------------------------------------
module lpd_frame_parser
   import lpd_pkg::*;
#(
   parameter int HEADER_BYTES = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [7:0]  data_byte,
   input  logic        chunk_end,
   input  logic [31:0] max_body_length,
   output logic        res_valid,
   output result_type  res
);

   localparam int CountWidth = $clog2(HEADER_BYTES);
   localparam logic [CountWidth-1:0] LastIndex = CountWidth'(HEADER_BYTES - 1);

   logic [1:0]            phase_ff,        phase_in;
   logic [CountWidth-1:0] header_count_ff, header_count_in;
   logic [15:0]           command_ff,      command_in;
   logic [31:0]           length_ff,       length_in;
   logic [31:0]           remaining_ff,    remaining_in;

   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic        last;

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      command_in      = command_ff;
      length_in       = length_ff;
      remaining_in    = remaining_ff;
      res_valid       = 1'b0;
      kind            = KIND_BYTE;
      out_byte        = 8'd0;
      last            = 1'b0;

      if (fire) begin
         unique case (phase_ff)
            PH_BODY: begin
               res_valid = 1'b1;
               kind      = KIND_BYTE;
               out_byte  = data_byte;
               last      = (remaining_ff <= 32'd1);
               if (last) begin
                  remaining_in = '0;
                  phase_in     = PH_HEADER;
               end else begin
                  remaining_in = remaining_ff - 32'd1;
               end
            end
            PH_DISCARD: begin
               if (chunk_end) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               // Header phase; the unused phase code behaves the same way.
               phase_in = PH_HEADER;
               if (header_count_ff == '0) begin
                  command_in = '0;
                  length_in  = '0;
               end
               if (header_count_ff == CountWidth'(HDR_CMD_OFFSET)) begin
                  command_in[7:0] = data_byte;
               end
               if (header_count_ff == CountWidth'(HDR_CMD_OFFSET + 1)) begin
                  command_in[15:8] = data_byte;
               end
               for (int i = 0; i < LEN_BYTES; i++) begin
                  if (header_count_ff == CountWidth'(HDR_LEN_OFFSET + i)) begin
                     length_in[8*i +: 8] = data_byte;
                  end
               end

               if (header_count_ff != LastIndex) begin
                  header_count_in = header_count_ff + CountWidth'(1);
               end else begin
                  header_count_in = '0;
                  if (length_in >= max_body_length) begin
                     res_valid = 1'b1;
                     kind      = KIND_ERROR;
                     last      = 1'b1;
                     // With the chunk already over there is nothing to skip.
                     phase_in  = chunk_end ? PH_HEADER : PH_DISCARD;
                  end else if (length_in == '0) begin
                     res_valid = 1'b1;
                     kind      = KIND_EMPTY;
                     last      = 1'b1;
                  end else begin
                     remaining_in = length_in;
                     phase_in     = PH_BODY;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      res.result_kind       = kind;
      res.body_byte         = out_byte;
      res.command_code      = command_in;
      res.frame_body_length = length_in;
      res.packet_last       = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         command_ff      <= '0;
         length_ff       <= '0;
         remaining_ff    <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         command_ff      <= command_in;
         length_ff       <= length_in;
         remaining_ff    <= remaining_in;
      end
   end

endmodule

// File: rtl/lpd_result_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result for the output channel and signals back-pressure.
// ----------------------------------------------------------------------------
module lpd_result_reg
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   input  result_type load_data,
   input  logic       out_stall,
   output logic       out_valid,
   output result_type out_data,
   output logic       hold
);

   logic       valid_ff, valid_in;
   result_type data_ff;
   logic       take;

   // The register can take a new result when it is empty or being drained.
   assign take     = !valid_ff || !out_stall;
   assign hold     = !take;
   assign valid_in = take ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Splits a byte stream into frames and streams out each body byte.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one stream byte per request plus a chunk_end mark.
// Each frame has a header of HEADER_BYTES bytes: command id in bytes 2-3 and
// body length in bytes 4-7, both little-endian. The rsp channel returns one
// result per body byte, one empty-packet result for a zero-length body, or
// one error result when the length is at or above max_body_length; after an
// error the rest of the chunk is dropped. Header bytes give no result.
// The csr channel writes max_body_length (8192 after reset); it is always
// ready and should be written only while the block is idle.
// A result is registered and appears the cycle after its request; throughput
// is one byte per cycle without rsp_stall, set by the single result register.
// When the receiver stalls with a result held, req_stall rises in the same
// cycle and stays high until that result is taken.
// Reset returns the parser to the start of a header and empties the result
// register.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer
   import lpd_pkg::*;
#(
   parameter int HEADER_BYTES = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_chunk_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_body_byte,
   output logic [15:0] rsp_command_code,
   output logic [31:0] rsp_frame_body_length,
   output logic        rsp_packet_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_max_body_length
);

   logic [31:0] max_len_ff;
   logic        fire;
   logic        res_valid;
   result_type  res;
   result_type  rsp_data;
   logic        hold;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_BODY_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_body_length;
      end
   end

   assign req_stall = hold;
   assign fire      = req_valid && !req_stall;

   lpd_frame_parser #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .data_byte      (req_data_byte),
      .chunk_end      (req_chunk_end),
      .max_body_length(max_len_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   lpd_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load_valid(res_valid),
      .load_data (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .hold      (hold)
   );

   assign rsp_result_kind       = rsp_data.result_kind;
   assign rsp_body_byte         = rsp_data.body_byte;
   assign rsp_command_code      = rsp_data.command_code;
   assign rsp_frame_body_length = rsp_data.frame_body_length;
   assign rsp_packet_last       = rsp_data.packet_last;

`ifndef SYNTH
   a_ctrl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_BYTE |-> rsp_packet_last)
      else $error("empty or error result without packet_last");

   a_ctrl_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_BYTE |-> rsp_body_byte == 8'd0)
      else $error("empty or error result carries a data byte");

   a_stall_cause: assert property (@(posedge clock)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled with no result held");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
